// ===== hdl/rwg_pkg.sv =====
// Shared types and constants for the replay window guard.
// Used by rwg_cfg, rwg_core and replay_window_guard_unit; no dependencies.
package rwg_pkg;

  localparam int WINDOW_SIZE = 64;
  localparam int WIN_IDX_W   = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int SEQ_W       = 64;
  localparam int TIME_W      = 48;
  localparam int CFG_W       = 32;
  localparam int CNT_W       = 32;
  localparam int ADDR_W      = 3;
  localparam int IN_W        = SEQ_W + 2 * TIME_W;
  localparam int RES_W       = 2 + 2 * CNT_W;
  localparam int OUT_W       = ((RES_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    DEC_ACCEPT = 2'd0,
    DEC_FUTURE = 2'd1,
    DEC_STALE  = 2'd2,
    DEC_DUP    = 2'd3
  } decision_t;

  typedef enum logic {
    REG_STALENESS = 1'b0,
    REG_SKEW      = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] staleness_limit_ms;
    logic [CFG_W-1:0] future_skew_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_time_ms;
    logic [TIME_W-1:0] packet_time_ms;
    logic [SEQ_W-1:0]  sequence_number;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] rejected_total;
    logic [CNT_W-1:0] accepted_total;
    decision_t        decision;
  } result_t;

endpackage

// ===== hdl/rwg_cfg.sv =====
// APB-style register file for the replay window guard.
// Depends on rwg_pkg for the register index codes and cfg_t.
module rwg_cfg
  import rwg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_STALENESS: cfg.staleness_limit_ms <= pwdata;
        REG_SKEW:      cfg.future_skew_ms     <= pwdata;
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_STALENESS: prdata = cfg.staleness_limit_ms;
      REG_SKEW:      prdata = cfg.future_skew_ms;
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== hdl/rwg_core.sv =====
// Decision logic and replay state (bitmap, highest sequence, last time, counters).
// Depends on rwg_pkg; state advances only on a step.
module rwg_core
  import rwg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic [WINDOW_SIZE-1:0] seen_window, seen_window_next;
  logic [SEQ_W-1:0]       highest_sequence, highest_sequence_next;
  logic [TIME_W-1:0]      last_accept_time, last_accept_time_next;
  logic [CNT_W-1:0]       accept_count, accept_count_next;
  logic [CNT_W-1:0]       reject_count, reject_count_next;

  logic [TIME_W:0]  future_lim;
  logic [TIME_W:0]  stale_sum;
  logic             is_future, is_stale, is_newer;
  logic [SEQ_W-1:0] gap, off;
  decision_t        decision;

  // Time checks at one extra bit so nothing wraps.
  assign future_lim = {1'b0, item.now_time_ms} + (TIME_W+1)'(cfg.future_skew_ms);
  assign stale_sum  = {1'b0, item.packet_time_ms} + (TIME_W+1)'(cfg.staleness_limit_ms);
  assign is_future  = {1'b0, item.packet_time_ms} > future_lim;
  assign is_stale   = (last_accept_time != '0) && (stale_sum < {1'b0, last_accept_time});
  assign is_newer   = item.sequence_number > highest_sequence;
  assign gap        = item.sequence_number - highest_sequence;
  assign off        = highest_sequence - item.sequence_number;

  always_comb begin
    seen_window_next      = seen_window;
    highest_sequence_next = highest_sequence;
    last_accept_time_next = last_accept_time;
    decision              = DEC_ACCEPT;
    if (is_future) begin
      decision = DEC_FUTURE;
    end else if (is_stale) begin
      decision = DEC_STALE;
    end else if (is_newer) begin
      // Slide the window; a gap of a whole window or more clears it.
      if (gap >= SEQ_W'(WINDOW_SIZE)) begin
        seen_window_next = '0;
      end else begin
        seen_window_next = seen_window << gap[WIN_IDX_W-1:0];
      end
      seen_window_next[0]   = 1'b1;
      highest_sequence_next = item.sequence_number;
      last_accept_time_next = item.packet_time_ms;
    end else if (off >= SEQ_W'(WINDOW_SIZE)) begin
      decision = DEC_DUP;
    end else if (seen_window[off[WIN_IDX_W-1:0]]) begin
      decision = DEC_DUP;
    end else begin
      seen_window_next[off[WIN_IDX_W-1:0]] = 1'b1;
    end
  end

  always_comb begin
    accept_count_next = accept_count;
    reject_count_next = reject_count;
    if (decision == DEC_ACCEPT) begin
      if (accept_count != CNT_MAX) accept_count_next = accept_count + 1'b1;
    end else begin
      if (reject_count != CNT_MAX) reject_count_next = reject_count + 1'b1;
    end
  end

  assign res.decision       = decision;
  assign res.accepted_total = accept_count_next;
  assign res.rejected_total = reject_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_window      <= '0;
      highest_sequence <= '0;
      last_accept_time <= '0;
      accept_count     <= '0;
      reject_count     <= '0;
    end else if (step) begin
      seen_window      <= seen_window_next;
      highest_sequence <= highest_sequence_next;
      last_accept_time <= last_accept_time_next;
      accept_count     <= accept_count_next;
      reject_count     <= reject_count_next;
    end
  end

  a_accept_inc: assert property (@(posedge clk) disable iff (rst)
    step && decision == DEC_ACCEPT && accept_count != CNT_MAX
    |=> accept_count == $past(accept_count) + 1'b1)
    else $error("accept counter did not advance on an accepted packet");

  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    step && decision != DEC_ACCEPT |=> accept_count == $past(accept_count))
    else $error("accept counter moved on a rejected packet");

  a_window_adv: assert property (@(posedge clk) disable iff (rst)
    step && !is_future && !is_stale && is_newer
    |=> seen_window[0] && highest_sequence == $past(item.sequence_number))
    else $error("window advance did not load the new head");

endmodule

// ===== hdl/replay_window_guard_unit.sv =====
// Replay window guard: timestamp checks plus a sliding anti-replay bitmap.
// A beat passes the input register, then the result register; one beat per cycle
// while m_tready is high. Bitmap and counters update on each step in rwg_core.
// Reset (rst, synchronous, active high) clears valid flags, bitmap, head, last time
// and counters at once; no clearing pass, so beats are taken from the first cycle.
// Depends on rwg_pkg, rwg_cfg and rwg_core.
module replay_window_guard_unit
  import rwg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  // s_tdata: sequence_number[63:0], packet_time_ms[111:64], now_time_ms[159:112]
  input  logic [IN_W-1:0]   s_tdata,
  // Result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  // m_tdata: decision[1:0], accepted_total[33:2], rejected_total[65:34], zeros above
  output logic [OUT_W-1:0]  m_tdata,
  // Configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    out_valid;
  result_t res_comb;
  result_t res;
  logic    advance;
  logic    s_fire;

  rwg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Move the held beat into the result register whenever that slot is free
  // or being drained this cycle; the input slot then frees up in the same edge.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_fire   = s_tvalid && s_tready;

  rwg_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_item),
    .cfg  (cfg),
    .res  (res_comb)
  );

  // Input register: hold the beat until the check consumes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) in_item <= item_t'(s_tdata);
  end

  // Result register: hold the verdict until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res <= res_comb;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'(res);

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && out_valid && !m_tready)
    else $error("input stalled without a blocked result");

  a_adv_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("checked beat did not reach the result register");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |=> out_valid && $stable(res))
    else $error("result beat changed while stalled");

endmodule
